/* hdl/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
// Used by the front end, back end, top level and checker; depends on nothing.
`timescale 1ns / 1ps
package rau_pkg;
  localparam int IO_BITS = 32;
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic signed [IO_BITS-1:0] a_num;
    logic signed [IO_BITS-1:0] a_den;
    logic signed [IO_BITS-1:0] b_num;
    logic signed [IO_BITS-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0] res_num;
    logic signed [IO_BITS-1:0] res_den;
    logic overflow;
    logic undefined;
  } out_word_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_MUL1, FS_MUL2, FS_MUL3, FS_SUM, FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_GCD, BS_DIVN, BS_DIVD, BS_DONE
  } back_state_t;
endpackage

/* hdl/rau_divider.sv */
// Restoring magnitude divider, one quotient bit per cycle.
// Depends on nothing; used by the back end for gcd and reduction steps.
`timescale 1ns / 1ps
module rau_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = '0;
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {r_r, q_r[W-1]} - {1'b0, d_r};
      if (!trial[W]) begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[W-2:0], q_r[W-1]};
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quotient = q_r;
  assign remainder = r_r;
endmodule

/* hdl/rau_front.sv */
// Front end: takes an input word and forms the unreduced fraction with its overflow flag.
// Depends on rau_pkg; feeds the queue in front of the back end.
`timescale 1ns / 1ps
module rau_front #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  rau_pkg::in_word_t  in_word,
  output logic               in_full,
  output logic               q_push,
  output logic [2*W:0]       q_data,
  input  logic               q_full
);
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
  rau_pkg::front_state_t st_r, st_nxt;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r, an_nxt, ad_nxt, bn_nxt, bd_nxt;
  logic [W-1:0] p_r, p_nxt, n_r, n_nxt, d_r, d_nxt;
  logic [1:0] act_r, act_nxt;
  logic ovf_r, ovf_nxt;
  logic [W-1:0] mx, my, mprod, s;
  logic movf, xneg, yneg;
  logic [W-1:0] mx_mag, my_mag;
  logic [2*W-1:0] mag_prod;

  function automatic logic [W-1:0] ld(input logic [rau_pkg::IO_BITS-1:0] v);
    logic [W+rau_pkg::IO_BITS-1:0] e;
    e = {{W{v[rau_pkg::IO_BITS-1]}}, v};
    return e[W-1:0];
  endfunction

  always_comb begin
    mx = an_r;
    my = bd_r;
    case (st_r)
      rau_pkg::FS_MUL1: begin
        mx = an_r;
        my = (act_r == rau_pkg::ACT_MUL) ? bn_r : bd_r;
      end
      rau_pkg::FS_MUL2: begin
        mx = ad_r;
        my = (act_r == rau_pkg::ACT_DIV) ? bn_r : bd_r;
      end
      rau_pkg::FS_MUL3: begin
        mx = bn_r;
        my = ad_r;
      end
      default: begin
        mx = an_r;
        my = bd_r;
      end
    endcase
    xneg = mx[W-1];
    yneg = my[W-1];
    mx_mag = xneg ? -mx : mx;
    my_mag = yneg ? -my : my;
    mag_prod = {{W{1'b0}}, mx_mag} * {{W{1'b0}}, my_mag};
    if (xneg != yneg) movf = mag_prod > {{W{1'b0}}, SIGN};
    else movf = mag_prod > {{W{1'b0}}, SIGN - 1'b1};
    mprod = (xneg != yneg) ? -mag_prod[W-1:0] : mag_prod[W-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rau_pkg::FS_IDLE: if (in_push) begin
        if (in_word.action == rau_pkg::ACT_MUL || in_word.action == rau_pkg::ACT_DIV ||
            ld(in_word.a_den) != ld(in_word.b_den)) st_nxt = rau_pkg::FS_MUL1;
        else st_nxt = rau_pkg::FS_SUM;
      end
      rau_pkg::FS_MUL1: st_nxt = rau_pkg::FS_MUL2;
      rau_pkg::FS_MUL2: st_nxt = (act_r == rau_pkg::ACT_MUL || act_r == rau_pkg::ACT_DIV) ?
                                 rau_pkg::FS_PUSH : rau_pkg::FS_MUL3;
      rau_pkg::FS_MUL3: st_nxt = rau_pkg::FS_SUM;
      rau_pkg::FS_SUM:  st_nxt = rau_pkg::FS_PUSH;
      rau_pkg::FS_PUSH: if (!q_full) st_nxt = rau_pkg::FS_IDLE;
      default: st_nxt = rau_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    act_nxt = act_r; ovf_nxt = ovf_r; p_nxt = p_r; n_nxt = n_r; d_nxt = d_r;
    s = '0;
    case (st_r)
      rau_pkg::FS_IDLE: if (in_push) begin
        act_nxt = in_word.action;
        an_nxt = ld(in_word.a_num);
        ad_nxt = ld(in_word.a_den);
        bd_nxt = ld(in_word.b_den);
        bn_nxt = ld(in_word.b_num);
        ovf_nxt = 1'b0;
        if (in_word.action == rau_pkg::ACT_SUB) begin
          bn_nxt = -ld(in_word.b_num);
          ovf_nxt = ld(in_word.b_num) == SIGN;
        end
        p_nxt = an_nxt;
        n_nxt = bn_nxt;
        d_nxt = ad_nxt;
      end
      rau_pkg::FS_MUL1: begin
        p_nxt = mprod; n_nxt = mprod; ovf_nxt = ovf_r | movf;
      end
      rau_pkg::FS_MUL2: begin
        d_nxt = mprod; ovf_nxt = ovf_r | movf;
      end
      rau_pkg::FS_MUL3: begin
        n_nxt = mprod; ovf_nxt = ovf_r | movf;
      end
      rau_pkg::FS_SUM: begin
        s = p_r + n_r;
        n_nxt = s;
        if (p_r[W-1] == n_r[W-1] && s[W-1] != p_r[W-1]) ovf_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= rau_pkg::FS_IDLE;
    else st_r <= st_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    act_r <= act_nxt; ovf_r <= ovf_nxt; p_r <= p_nxt; n_r <= n_nxt; d_r <= d_nxt;
  end

  assign in_full = (st_r != rau_pkg::FS_IDLE);
  assign q_push = (st_r == rau_pkg::FS_PUSH) && !q_full;
  assign q_data = {n_r, d_r, ovf_r};
endmodule

/* hdl/rau_queue.sv */
// Two-entry queue between front and back ends.
// Depends on nothing.
`timescale 1ns / 1ps
module rau_queue #(
  parameter int DW = 65
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);
  logic [DW-1:0] m_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) m_r[wp_r] <= wdata;
  end

  assign full = cnt_r[1];
  assign empty = (cnt_r == 2'd0);
  assign rdata = m_r[rp_r];
endmodule

/* hdl/rau_back.sv */
// Back end: Euclidean gcd and reduction on a shared sequential divider.
// Depends on rau_pkg and rau_divider.
`timescale 1ns / 1ps
module rau_back #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [2*W:0]       q_data,
  output logic               q_pop,
  output logic               out_empty,
  output rau_pkg::out_word_t out_word,
  input  logic               out_pop
);
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
  rau_pkg::back_state_t st_r, st_nxt;
  logic [W-1:0] n_r, d_r, a_r, b_r, rn_r, n_nxt, d_nxt, a_nxt, b_nxt, rn_nxt;
  logic ovf_r, ovf_nxt, und_r, und_nxt, go_r, go_nxt;
  logic [W-1:0] rd_r, rd_nxt;
  logic dv_start, dv_done;
  logic [W-1:0] dv_a, dv_b, dv_q, dv_rm, sdiv, sq;
  logic sneg;

  rau_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q), .remainder(dv_rm)
  );

  always_comb begin
    sdiv = a_r;
    case (st_r)
      rau_pkg::BS_DIVN: sdiv = n_r;
      rau_pkg::BS_DIVD: sdiv = d_r;
      default: sdiv = a_r;
    endcase
    dv_a = sdiv[W-1] ? -sdiv : sdiv;
    dv_b = b_r[W-1] ? -b_r : b_r;
    sneg = sdiv[W-1] != b_r[W-1];
    sq = sneg ? -dv_q : dv_q;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rau_pkg::BS_IDLE: if (!q_empty) st_nxt = rau_pkg::BS_GCD;
      rau_pkg::BS_GCD: if (!go_r) begin
        if (b_r == '0) st_nxt = (a_r == '0) ? rau_pkg::BS_DONE : rau_pkg::BS_DIVN;
      end
      rau_pkg::BS_DIVN: if (go_r && dv_done) st_nxt = rau_pkg::BS_DIVD;
      rau_pkg::BS_DIVD: if (go_r && dv_done) st_nxt = rau_pkg::BS_DONE;
      rau_pkg::BS_DONE: if (out_pop) st_nxt = rau_pkg::BS_IDLE;
      default: st_nxt = rau_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    n_nxt = n_r; d_nxt = d_r; a_nxt = a_r; b_nxt = b_r; rn_nxt = rn_r; rd_nxt = rd_r;
    ovf_nxt = ovf_r; und_nxt = und_r; go_nxt = go_r; dv_start = 1'b0;
    case (st_r)
      rau_pkg::BS_IDLE: if (!q_empty) begin
        n_nxt = q_data[2*W:W+1];
        d_nxt = q_data[W:1];
        ovf_nxt = q_data[0];
        a_nxt = q_data[2*W:W+1];
        b_nxt = q_data[W:1];
        und_nxt = 1'b0;
        go_nxt = 1'b0;
      end
      rau_pkg::BS_GCD: begin
        if (go_r) begin
          if (dv_done) begin
            go_nxt = 1'b0;
            a_nxt = b_r;
            b_nxt = a_r[W-1] ? -dv_rm : dv_rm;
          end
        end else if (b_r != '0) begin
          dv_start = 1'b1;
          go_nxt = 1'b1;
        end else if (a_r == '0) begin
          und_nxt = 1'b1; rn_nxt = '0; rd_nxt = '0;
        end else begin
          b_nxt = a_r;
        end
      end
      rau_pkg::BS_DIVN: begin
        if (!go_r) begin
          dv_start = 1'b1;
          go_nxt = 1'b1;
        end else if (dv_done) begin
          go_nxt = 1'b0;
          rn_nxt = sq;
          if (!sneg && dv_q == SIGN) ovf_nxt = 1'b1;
        end
      end
      rau_pkg::BS_DIVD: begin
        if (!go_r) begin
          dv_start = 1'b1;
          go_nxt = 1'b1;
        end else if (dv_done) begin
          go_nxt = 1'b0;
          rd_nxt = sq;
          if (!sneg && dv_q == SIGN) ovf_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rau_pkg::BS_IDLE;
      go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      go_r <= go_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; a_r <= a_nxt; b_r <= b_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; ovf_r <= ovf_nxt; und_r <= und_nxt;
  end

  assign q_pop = (st_r == rau_pkg::BS_IDLE) && !q_empty;
  assign out_empty = (st_r != rau_pkg::BS_DONE);
  assign out_word.res_num = rau_pkg::IO_BITS'($signed(rn_r));
  assign out_word.res_den = rau_pkg::IO_BITS'($signed(rd_r));
  assign out_word.overflow = ovf_r;
  assign out_word.undefined = und_r;
endmodule

/* hdl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_front, rau_queue, rau_back and rau_divider.
`timescale 1ns / 1ps
// A word is taken when in_push is high and in_full low; its reduced fraction appears
// once out_empty falls. The front end stays busy after taking a word until it has pushed
// the unreduced fraction into the queue; the back end runs one division per Euclid
// remainder step, up to about 46 steps, plus two more divisions for reduction, all on
// the single bit-serial divider in the back end.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  rau_pkg::in_word_t  in_word,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output rau_pkg::out_word_t out_word
);
  localparam int QW = 2 * WORD_BITS + 1;
  logic f_push, q_full, q_empty, q_pop;
  logic [QW-1:0] f_data, q_data;

  rau_front #(.W(WORD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_word(in_word), .in_full(in_full),
    .q_push(f_push), .q_data(f_data), .q_full(q_full)
  );

  rau_queue #(.DW(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(f_push), .wdata(f_data), .full(q_full),
    .pop(q_pop), .rdata(q_data), .empty(q_empty)
  );

  rau_back #(.W(WORD_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_empty(out_empty), .out_word(out_word), .out_pop(out_pop)
  );
endmodule

/* hdl/rau_checker.sv */
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input rau_pkg::out_word_t out_word
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_word)) else $error("word dropped");
  a_undef: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_word.undefined |-> out_word.res_num == '0 && out_word.res_den == '0)
    else $error("undefined not zero");
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("reset state");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_full(in_full), .out_empty(out_empty),
  .out_pop(out_pop), .out_word(out_word)
);
